FILE: rtl/bsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared constants and types for the descending character sorter.
// ----------------------------------------------------------------------------
package bsd_pkg;

	// depth of the cell chain (most characters held in one string)
	localparam int MAX_LEN = 63;
	// character width
	localparam int CH_W    = 7;

	typedef logic [CH_W-1:0] ch_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;    // insert the broadcast character
		logic shift;  // move every entry one cell toward the head
	} cell_ctl_t;

endpackage : bsd_pkg

FILE: rtl/byte_string_sorter_descending.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_string_sorter_descending
// Collects characters of a string in a sorted cell chain and, on a zero
// character, emits them highest code first followed by a zero marked last.
// ----------------------------------------------------------------------------
//  channel | valid     | stall     | payload
//  input   | ch_valid  | ch_stall  | ch
//  output  | res_valid | res_stall | out_ch, last, overflow
//
//  a non-zero character is taken while collecting; every cell compares it at once
//  and the chain opens a slot in the same edge
//  a zero character gives n + 1 results (n = characters held, at most
//  63), as entries leave one at a time through the head cell of the chain
//  the input is stalled while results drain; output stalls simply hold the head
//  reset empties the chain through the occupied bits; no clearing pass
// ----------------------------------------------------------------------------
module byte_string_sorter_descending (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         ch_valid,
	output logic         ch_stall,
	input  bsd_pkg::ch_t ch,
	output logic         res_valid,
	input  logic         res_stall,
	output bsd_pkg::ch_t out_ch,
	output logic         last,
	output logic         overflow
);
	import bsd_pkg::*;

	logic      drain_q;
	logic      drop_q;
	ch_t       head_data;
	logic      head_valid;
	logic      full;
	logic      in_acc;
	logic      out_acc;
	logic      term;
	cell_ctl_t ctl;

	assign in_acc  = ch_valid && !ch_stall;
	assign out_acc = res_valid && !res_stall;
	assign term    = (ch == '0);

	// chain commands
	always_comb begin
		ctl.ins   = in_acc && !term && !full;
		ctl.shift = out_acc && head_valid;
	end

	bsd_chain u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.ch         (ch),
		.head_data  (head_data),
		.head_valid (head_valid),
		.full       (full)
	);

	// drain mode and dropped-character flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
			drop_q  <= 1'b0;
		end else begin
			if (in_acc && term) begin
				drain_q <= 1'b1;
			end else if (out_acc && !head_valid) begin
				drain_q <= 1'b0;
				drop_q  <= 1'b0;
			end
			if (in_acc && !term && full) begin
				drop_q <= 1'b1;
			end
		end
	end

	// result comes straight from the head cell
	assign ch_stall  = drain_q;
	assign res_valid = drain_q;
	assign out_ch    = head_valid ? head_data : '0;
	assign last      = !head_valid;
	assign overflow  = !head_valid && drop_q;

`ifndef SYNTH
	// a character arriving at a full chain raises the flag
	a_drop_set: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !term && full) |=> drop_q)
		else $error("dropped character not flagged");

	// a terminator starts the result run
	a_term_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && term) |=> res_valid)
		else $error("terminator did not start results");

	// the flag is only ever set with a full chain while collecting
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(drop_q && !drain_q) |-> full)
		else $error("overflow flag without a full chain");

	// the run ends after the terminator result is taken
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last) |=> (!res_valid && !head_valid))
		else $error("results continued after terminator");
`endif

endmodule : byte_string_sorter_descending

FILE: rtl/bsd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_cell
// One slot of the sorted chain: holds a character and its occupied bit.
// ----------------------------------------------------------------------------
module bsd_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  bsd_pkg::cell_ctl_t ctl,
	input  bsd_pkg::ch_t      ch,
	input  logic              prev_keep,
	input  bsd_pkg::ch_t      prev_data,
	input  logic              prev_valid,
	input  bsd_pkg::ch_t      next_data,
	input  logic              next_valid,
	output logic              keep,
	output bsd_pkg::ch_t      data,
	output logic              valid
);
	import bsd_pkg::*;

	ch_t  data_q;
	logic valid_q;
	ch_t  data_d;
	logic valid_d;
	logic load;

	// entry stays put when it is not smaller than the new character
	assign keep = valid_q && (data_q >= ch);

	// next contents: shift toward head, take the new character, or take the left entry
	always_comb begin
		data_d  = data_q;
		valid_d = valid_q;
		load    = 1'b0;
		if (ctl.shift) begin
			data_d  = next_data;
			valid_d = next_valid;
			load    = 1'b1;
		end else if (ctl.ins && !keep) begin
			load = 1'b1;
			if (prev_keep) begin
				data_d  = ch;
				valid_d = 1'b1;
			end else begin
				data_d  = prev_data;
				valid_d = prev_valid;
			end
		end
	end

	// occupied bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= valid_d;
		end
	end

	// character payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data_d;
		end
	end

	assign data  = data_q;
	assign valid = valid_q;

endmodule : bsd_cell

FILE: rtl/bsd_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_chain
// Row of cells kept in descending order; head cell holds the largest entry.
// ----------------------------------------------------------------------------
module bsd_chain (
	input  logic               clk,
	input  logic               arst_n,
	input  bsd_pkg::cell_ctl_t ctl,
	input  bsd_pkg::ch_t       ch,
	output bsd_pkg::ch_t       head_data,
	output logic               head_valid,
	output logic               full
);
	import bsd_pkg::*;

	ch_t  data  [MAX_LEN];
	logic valid [MAX_LEN];
	logic keep  [MAX_LEN];

	// neighbor wiring with fixed values at both ends
	for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
		logic pk;
		ch_t  pd;
		logic pv;
		ch_t  nd;
		logic nv;

		if (i == 0) begin : g_head
			assign pk = 1'b1;
			assign pd = '0;
			assign pv = 1'b0;
		end else begin : g_mid
			assign pk = keep[i-1];
			assign pd = data[i-1];
			assign pv = valid[i-1];
		end

		if (i == MAX_LEN - 1) begin : g_tail
			assign nd = '0;
			assign nv = 1'b0;
		end else begin : g_body
			assign nd = data[i+1];
			assign nv = valid[i+1];
		end

		bsd_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.ch         (ch),
			.prev_keep  (pk),
			.prev_data  (pd),
			.prev_valid (pv),
			.next_data  (nd),
			.next_valid (nv),
			.keep       (keep[i]),
			.data       (data[i]),
			.valid      (valid[i])
		);
	end

	assign head_data  = data[0];
	assign head_valid = valid[0];
	assign full       = valid[MAX_LEN-1];

endmodule : bsd_chain

FILE: sim/byte_string_sorter_descending_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_string_sorter_descending_tb
// Feeds strings of 7-bit characters, each closed by a zero, into the sorter.
// A scoreboard keeps its own descending store and drop flag, predicts every
// sorted run with its terminator, and checks each result item field by field
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module byte_string_sorter_descending_tb;
	import bsd_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 280;
	localparam int PHASE_ITEMS   = 70;
	localparam int DRAIN_CYCLES  = 80;
	localparam int REPORT_LIMIT  = 10;
	localparam ch_t TERMINATOR   = '0;

	// one result item of a sorted run
	typedef struct packed {
		ch_t  out_ch;
		logic last;
		logic overflow;
	} sort_result_t;

	// descending store and the runs it is expected to emit
	class sorted_run_scoreboard;
		ch_t          held[$];
		bit           dropped;
		sort_result_t pending[$];
		int unsigned  mismatches;

		// update the store for one accepted character
		function void note_char(ch_t c);
			int           pos;
			sort_result_t r;
			if (c != TERMINATOR) begin
				if (held.size() < MAX_LEN) begin
					pos = 0;
					while (pos < held.size() && held[pos] >= c)
						pos++;
					held.insert(pos, c);
				end else begin
					dropped = 1'b1;
				end
			end else begin
				foreach (held[i]) begin
					r.out_ch   = held[i];
					r.last     = 1'b0;
					r.overflow = 1'b0;
					pending.push_back(r);
				end
				r.out_ch   = TERMINATOR;
				r.last     = 1'b1;
				r.overflow = dropped;
				pending.push_back(r);
				held.delete();
				dropped = 1'b0;
			end
		endfunction

		// compare one accepted result with the oldest expected one
		function void check_result(ch_t out_ch, logic last, logic overflow);
			sort_result_t exp_r;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected result out_ch=%0d last=%0b overflow=%0b",
						$realtime, out_ch, last, overflow);
				return;
			end
			exp_r = pending.pop_front();
			if (out_ch !== exp_r.out_ch || last !== exp_r.last ||
				overflow !== exp_r.overflow) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("%0t: expected out_ch=%0d last=%0b overflow=%0b",
						$realtime, exp_r.out_ch, exp_r.last, exp_r.overflow);
					$display("%0t:      got out_ch=%0d last=%0b overflow=%0b",
						$realtime, out_ch, last, overflow);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic ch_valid;
	logic ch_stall;
	ch_t  ch;
	logic res_valid;
	logic res_stall = 1'b0;
	ch_t  out_ch;
	logic last;
	logic overflow;

	sorted_run_scoreboard board;
	int unsigned          send_idle_pct = 0;
	int unsigned          stall_pct     = 0;
	int unsigned          cycle_count   = 0;

	byte_string_sorter_descending u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.ch_valid (ch_valid),
		.ch_stall (ch_stall),
		.ch       (ch),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.out_ch   (out_ch),
		.last     (last),
		.overflow (overflow)
	);

	always #2 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result side: check accepted items, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			board.check_result(out_ch, last, overflow);
		res_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// present one character and hold it until taken
	task automatic send_char(input ch_t c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			ch_valid <= 1'b0;
			@(posedge clk);
		end
		ch_valid <= 1'b1;
		ch       <= c;
		@(posedge clk);
		while (ch_stall)
			@(posedge clk);
		board.note_char(c);
	endtask

	// random string of the given length, closed by a terminator
	task automatic send_string(input int len, input bit narrow);
		ch_t c;
		for (int i = 0; i < len; i++) begin
			// narrow alphabet forces runs of equal characters
			if (narrow)
				c = ch_t'($urandom_range(60, 63));
			else
				c = ch_t'($urandom_range(1, 127));
			send_char(c);
		end
		send_char(TERMINATOR);
	endtask

	// set idling for the current phase of the random part
	task automatic set_phase(input int phase);
		case (phase % 4)
			0: begin
				send_idle_pct = 0;
				stall_pct     = 0;
			end
			1: begin
				send_idle_pct = 69;
				stall_pct     = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct     = 69;
			end
			default: begin
				send_idle_pct = 14;
				stall_pct     = 14;
			end
		endcase
	endtask

	initial begin
		int sent;
		int len;
		int strings;
		int unsigned pick;

		board    = new();
		arst_n   <= 1'b0;
		ch_valid <= 1'b0;
		ch       <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty string
		send_char(TERMINATOR);
		// single character
		send_char(ch_t'(65));
		send_char(TERMINATOR);
		// highest and lowest codes
		send_char(ch_t'(127));
		send_char(ch_t'(1));
		send_char(TERMINATOR);
		// equal characters side by side
		send_char(ch_t'(98));
		send_char(ch_t'(98));
		send_char(ch_t'(97));
		send_char(ch_t'(98));
		send_char(TERMINATOR);
		// alternating bit patterns
		send_char(ch_t'(7'h55));
		send_char(ch_t'(7'h2A));
		send_char(TERMINATOR);
		// mixed order
		send_char(ch_t'(122));
		send_char(ch_t'(97));
		send_char(ch_t'(77));
		send_char(ch_t'(48));
		send_char(ch_t'(32));
		send_char(TERMINATOR);

		// random strings: an exactly full one, an overflowing one, then mostly short
		sent    = 0;
		strings = 0;
		while (sent < RANDOM_ITEMS) begin
			set_phase(sent / PHASE_ITEMS);
			pick = $urandom_range(0, 9);
			if (strings == 0)
				len = MAX_LEN;
			else if (strings == 1)
				len = MAX_LEN + 4;
			else if (pick == 0)
				len = 0;
			else if (pick == 1)
				len = $urandom_range(MAX_LEN - 2, MAX_LEN + 6);
			else
				len = $urandom_range(1, 8);
			send_string(len, $urandom_range(0, 3) == 0);
			sent    += len + 1;
			strings += 1;
		end
		ch_valid <= 1'b0;

		// drain outstanding results, then allow for stray ones
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/bsd_pkg.sv
rtl/bsd_cell.sv
rtl/bsd_chain.sv
rtl/byte_string_sorter_descending.sv
sim/byte_string_sorter_descending_tb.sv
